@@ hdl/lmd_pkg.sv @@
package lmd_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int LEN_BITS    = 16;
    localparam int HDR_BYTES   = 4;
    localparam int STORE_DEPTH = HDR_BYTES - 1;

    localparam logic [BYTE_BITS-1:0] FLAG_VALID_MASK = 8'h08;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_RESYNC = 2'd2
    } t_kind;

    typedef struct packed {
        logic                 valid;
        t_kind                kind;
        logic [BYTE_BITS-1:0] channel_id;
        logic [BYTE_BITS-1:0] flag_bits;
        logic [LEN_BITS-1:0]  body_length;
        logic [BYTE_BITS-1:0] payload_byte;
        logic                 is_last;
    } t_result;

endpackage

@@ hdl/lmd_in_if.sv @@
interface lmd_in_if;
    logic                          valid;
    logic                          ready;
    logic [lmd_pkg::BYTE_BITS-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hdl/lmd_out_if.sv @@
interface lmd_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [lmd_pkg::BYTE_BITS-1:0] channel_id;
    logic [lmd_pkg::BYTE_BITS-1:0] flag_bits;
    logic [lmd_pkg::LEN_BITS-1:0]  body_length;
    logic [lmd_pkg::BYTE_BITS-1:0] payload_byte;
    logic                          is_last;

    modport source (output valid, output kind, output channel_id, output flag_bits,
                    output body_length, output payload_byte, output is_last,
                    input ready);
    modport sink (input valid, input kind, input channel_id, input flag_bits,
                  input body_length, input payload_byte, input is_last,
                  output ready);
endinterface

@@ hdl/lmd_step.sv @@
module lmd_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [lmd_pkg::BYTE_BITS-1:0] i_byte,
    output lmd_pkg::t_result              o_result
);

    logic [lmd_pkg::BYTE_BITS-1:0] r_store [lmd_pkg::STORE_DEPTH];
    logic [lmd_pkg::BYTE_BITS-1:0] n_store [lmd_pkg::STORE_DEPTH];
    logic [1:0]                    r_fill, n_fill;
    logic                          r_in_body, n_in_body;
    logic [lmd_pkg::LEN_BITS-1:0]  r_left, n_left;
    logic [lmd_pkg::BYTE_BITS-1:0] r_chan, n_chan;
    logic [lmd_pkg::BYTE_BITS-1:0] r_flags, n_flags;
    logic [lmd_pkg::LEN_BITS-1:0]  r_len, n_len;

    logic [lmd_pkg::LEN_BITS-1:0]  cand_len;
    logic                          body_last;

    assign cand_len  = {r_store[2], i_byte};
    assign body_last = (r_left <= lmd_pkg::LEN_BITS'(1));

    always_comb begin
        n_store   = r_store;
        n_fill    = r_fill;
        n_in_body = r_in_body;
        n_left    = r_left;
        n_chan    = r_chan;
        n_flags   = r_flags;
        n_len     = r_len;

        o_result              = '0;
        o_result.kind         = lmd_pkg::KIND_HEADER;

        if (i_valid) begin
            if (r_in_body) begin
                o_result.valid        = 1'b1;
                o_result.kind         = lmd_pkg::KIND_BODY;
                o_result.channel_id   = r_chan;
                o_result.flag_bits    = r_flags;
                o_result.body_length  = r_len;
                o_result.payload_byte = i_byte;
                o_result.is_last      = body_last;
                if (body_last) begin
                    n_left    = '0;
                    n_in_body = 1'b0;
                end else begin
                    n_left = r_left - lmd_pkg::LEN_BITS'(1);
                end
            end else if (r_fill != 2'd3) begin
                // gather the first three header bytes
                case (r_fill)
                    2'd0:    n_store[0] = i_byte;
                    2'd1:    n_store[1] = i_byte;
                    default: n_store[2] = i_byte;
                endcase
                n_fill = r_fill + 2'd1;
            end else if ((r_store[1] & lmd_pkg::FLAG_VALID_MASK) !=
                         lmd_pkg::FLAG_VALID_MASK) begin
                // bad flags: drop the oldest byte and slide the window
                o_result.valid        = 1'b1;
                o_result.kind         = lmd_pkg::KIND_RESYNC;
                o_result.channel_id   = r_store[0];
                o_result.flag_bits    = r_store[1];
                o_result.body_length  = cand_len;
                o_result.payload_byte = r_store[0];
                o_result.is_last      = 1'b0;
                n_store[0] = r_store[1];
                n_store[1] = r_store[2];
                n_store[2] = i_byte;
            end else begin
                o_result.valid        = 1'b1;
                o_result.kind         = lmd_pkg::KIND_HEADER;
                o_result.channel_id   = r_store[0];
                o_result.flag_bits    = r_store[1];
                o_result.body_length  = cand_len;
                o_result.payload_byte = '0;
                o_result.is_last      = (cand_len == '0);
                n_chan    = r_store[0];
                n_flags   = r_store[1];
                n_len     = cand_len;
                n_fill    = 2'd0;
                n_left    = cand_len;
                n_in_body = (cand_len != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 2'd0;
            r_in_body <= 1'b0;
            r_left    <= '0;
        end else begin
            r_fill    <= n_fill;
            r_in_body <= n_in_body;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_chan  <= n_chan;
        r_flags <= n_flags;
        r_len   <= n_len;
    end

endmodule

@@ hdl/length_prefixed_message_deframer.sv @@
// Length-prefixed message deframer.
// i_rx carries one received byte per transfer (valid/ready, accepted when
// both are high). o_tx carries one result record per transfer: a header
// record (kind 0), a body byte tagged with its channel (kind 1), or a resync
// record (kind 2) naming the byte dropped when a header's flags lack bit 3.
// Header bytes other than the fourth produce no record.
// Throughput: one byte per cycle sustained while o_tx is ready; the state
// update is compare/decrement logic between the input register and the
// result register.
// Each record passes the input register, then the result register, to o_tx.
// Reset (i_rst_n low, synchronous): both register stages empty, header
// gathering restarts from zero bytes, no body in progress.
// Receiver stall: the result register holds its record; the input register
// keeps accepting until it is also full, then i_rx.ready drops. No record
// is lost or repeated.
module length_prefixed_message_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lmd_in_if.sink    i_rx,
    lmd_out_if.source o_tx
);

    logic                          r_in_valid;
    logic [lmd_pkg::BYTE_BITS-1:0] r_in_byte;
    lmd_pkg::t_result              r_out;
    lmd_pkg::t_result              step_res;
    logic                          advance;

    // the step stage may run whenever the result register is free or draining
    assign advance    = r_in_valid && (!r_out.valid || o_tx.ready);
    assign i_rx.ready = !r_in_valid || advance;

    lmd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_byte   (r_in_byte),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out.kind         <= step_res.kind;
            r_out.channel_id   <= step_res.channel_id;
            r_out.flag_bits    <= step_res.flag_bits;
            r_out.body_length  <= step_res.body_length;
            r_out.payload_byte <= step_res.payload_byte;
            r_out.is_last      <= step_res.is_last;
        end
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance) begin
            r_out.valid <= step_res.valid;
        end else if (o_tx.ready) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_tx.valid        = r_out.valid;
    assign o_tx.kind         = r_out.kind;
    assign o_tx.channel_id   = r_out.channel_id;
    assign o_tx.flag_bits    = r_out.flag_bits;
    assign o_tx.body_length  = r_out.body_length;
    assign o_tx.payload_byte = r_out.payload_byte;
    assign o_tx.is_last      = r_out.is_last;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1850;
    localparam int TAIL_ITEMS   = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Zero-length header, a header with all-ones channel and flags and a
    // one-byte body, then flags lacking bit 3 three times before a header lines up.
    localparam logic [lmd_pkg::BYTE_BITS-1:0] DIRECTED [18] = '{
        8'h00, 8'h08, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF,
        8'hA5, 8'hF7, 8'h12, 8'h34, 8'h08, 8'h00, 8'h02, 8'h00, 8'h80
    };

    typedef struct {
        lmd_pkg::t_kind                kind;
        logic [lmd_pkg::BYTE_BITS-1:0] channel_id;
        logic [lmd_pkg::BYTE_BITS-1:0] flag_bits;
        logic [lmd_pkg::LEN_BITS-1:0]  body_length;
        logic [lmd_pkg::BYTE_BITS-1:0] payload_byte;
        logic                          is_last;
    } t_deframe_rec;

    logic clk;
    logic rst_n;

    lmd_in_if  rx_if ();
    lmd_out_if tx_if ();

    length_prefixed_message_deframer uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_tx    (tx_if)
    );

    logic [lmd_pkg::BYTE_BITS-1:0] pending_bytes [$];
    t_deframe_rec                  expected_records [$];

    // Deframer state as seen by the predictor
    logic [lmd_pkg::BYTE_BITS-1:0] hdr_bytes [lmd_pkg::STORE_DEPTH];
    logic [1:0]                    hdr_count;
    logic                          body_active;
    logic [lmd_pkg::LEN_BITS-1:0]  body_remaining;
    logic [lmd_pkg::BYTE_BITS-1:0] msg_channel;
    logic [lmd_pkg::BYTE_BITS-1:0] msg_flags;
    logic [lmd_pkg::LEN_BITS-1:0]  msg_length;

    bit failed;
    bit calm_tail;
    int accepted_bytes;
    int total_bytes;
    int gap_left;
    int stall_left;
    int cycle_count;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic void deframe_byte(input logic [lmd_pkg::BYTE_BITS-1:0] b);
        t_deframe_rec rec;
        if (body_active) begin
            rec.kind         = lmd_pkg::KIND_BODY;
            rec.channel_id   = msg_channel;
            rec.flag_bits    = msg_flags;
            rec.body_length  = msg_length;
            rec.payload_byte = b;
            rec.is_last      = (body_remaining <= 1);
            if (rec.is_last) begin
                body_remaining = '0;
                body_active    = 1'b0;
            end else begin
                body_remaining = body_remaining - 1'b1;
            end
            expected_records.push_back(rec);
            return;
        end
        if (hdr_count < lmd_pkg::STORE_DEPTH) begin
            hdr_bytes[hdr_count] = b;
            hdr_count            = hdr_count + 1'b1;
            return;
        end
        rec.channel_id  = hdr_bytes[0];
        rec.flag_bits   = hdr_bytes[1];
        rec.body_length = {hdr_bytes[2], b};
        if ((hdr_bytes[1] & lmd_pkg::FLAG_VALID_MASK) != lmd_pkg::FLAG_VALID_MASK) begin
            // drop the oldest byte, keep three gathered
            rec.kind         = lmd_pkg::KIND_RESYNC;
            rec.payload_byte = hdr_bytes[0];
            rec.is_last      = 1'b0;
            hdr_bytes[0]     = hdr_bytes[1];
            hdr_bytes[1]     = hdr_bytes[2];
            hdr_bytes[2]     = b;
        end else begin
            rec.kind         = lmd_pkg::KIND_HEADER;
            rec.payload_byte = '0;
            rec.is_last      = (rec.body_length == 0);
            msg_channel      = rec.channel_id;
            msg_flags        = rec.flag_bits;
            msg_length       = rec.body_length;
            body_remaining   = rec.body_length;
            body_active      = (rec.body_length != 0);
            hdr_count        = '0;
        end
        expected_records.push_back(rec);
    endfunction

    task automatic queue_message(input logic [lmd_pkg::BYTE_BITS-1:0] chan,
                                 input logic [lmd_pkg::BYTE_BITS-1:0] flags,
                                 input int len);
        logic [lmd_pkg::LEN_BITS-1:0] blen;
        blen = lmd_pkg::LEN_BITS'(len);
        pending_bytes.push_back(chan);
        pending_bytes.push_back(flags);
        pending_bytes.push_back(blen[15:8]);
        pending_bytes.push_back(blen[7:0]);
        repeat (len) pending_bytes.push_back(lmd_pkg::BYTE_BITS'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            failed = 1'b1;
        end
    endtask

    // Driver: hold a byte until its transfer, then present the next one, with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                deframe_byte(rx_if.rx_byte);
                accepted_bytes++;
            end
            calm_tail <= (pending_bytes.size() < TAIL_ITEMS);
            if (!rx_if.valid || rx_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_if.valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    rx_if.valid <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    rx_if.valid <= 1'b0;
                end else begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= pending_bytes.pop_front();
                end
            end
        end
    end

    // Monitor: compare each transfer with the oldest expected record; stall ready at random
    always @(posedge clk) begin
        t_deframe_rec want;
        if (!rst_n) begin
            tx_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (tx_if.valid && tx_if.ready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected record: kind %0d channel 0x%0h payload 0x%0h",
                           tx_if.kind, tx_if.channel_id, tx_if.payload_byte);
                    failed = 1'b1;
                end else begin
                    want = expected_records.pop_front();
                    check_field("kind", 16'(want.kind), 16'(tx_if.kind));
                    check_field("channel_id", 16'(want.channel_id), 16'(tx_if.channel_id));
                    check_field("flag_bits", 16'(want.flag_bits), 16'(tx_if.flag_bits));
                    check_field("body_length", want.body_length, tx_if.body_length);
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(tx_if.payload_byte));
                    check_field("is_last", 16'(want.is_last), 16'(tx_if.is_last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                tx_if.ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 3);
                tx_if.ready <= 1'b0;
            end else begin
                tx_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[length_prefixed_message_deframer] ERROR");
            $finish;
        end
    end

    initial begin
        int                            filler;
        int                            len;
        int                            noise_len;
        bit                            after_noise;
        logic [lmd_pkg::BYTE_BITS-1:0] chan;
        logic [lmd_pkg::BYTE_BITS-1:0] flags;

        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        tx_if.ready    = 1'b0;
        failed         = 1'b0;
        calm_tail      = 1'b0;
        accepted_bytes = 0;
        cycle_count    = 0;
        hdr_bytes      = '{default: '0};
        hdr_count      = '0;
        body_active    = 1'b0;
        body_remaining = '0;
        msg_channel    = '0;
        msg_flags      = '0;
        msg_length     = '0;

        foreach (DIRECTED[i]) pending_bytes.push_back(DIRECTED[i]);

        // Mostly well-formed messages; noise bytes have bit 3 clear so every
        // candidate built from them resyncs, and the channel byte after noise
        // has bit 3 clear too so the stream realigns on the next header.
        filler      = 0;
        after_noise = 1'b0;
        while (filler < RANDOM_ITEMS) begin
            if ($urandom_range(0, 6) == 0) begin
                noise_len = $urandom_range(1, 8);
                repeat (noise_len) begin
                    pending_bytes.push_back(lmd_pkg::BYTE_BITS'($urandom_range(0, 255)) &
                                            ~lmd_pkg::FLAG_VALID_MASK);
                end
                filler += noise_len;
                after_noise = 1'b1;
            end else begin
                chan  = lmd_pkg::BYTE_BITS'($urandom_range(0, 255));
                flags = lmd_pkg::BYTE_BITS'($urandom_range(0, 255)) | lmd_pkg::FLAG_VALID_MASK;
                if (after_noise) chan = chan & ~lmd_pkg::FLAG_VALID_MASK;
                case ($urandom_range(0, 9))
                    0, 1:    len = 0;
                    9:       len = $urandom_range(13, 300);
                    default: len = $urandom_range(1, 12);
                endcase
                queue_message(chan, flags, len);
                filler += 4 + len;
                after_noise = 1'b0;
            end
        end
        total_bytes = pending_bytes.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (accepted_bytes != total_bytes || expected_records.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failed || expected_records.size() != 0) begin
            $display("[length_prefixed_message_deframer] ERROR");
        end else begin
            $display("[length_prefixed_message_deframer] OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lmd_pkg.sv
hdl/lmd_in_if.sv
hdl/lmd_out_if.sv
hdl/lmd_step.sv
hdl/length_prefixed_message_deframer.sv
test/testbench.sv
